FILE: rtl/imu_frame_serializer_macros.svh
// Assertion macros for the frame serializer checker.
`ifndef IMU_FRAME_SERIALIZER_MACROS_SVH
`define IMU_FRAME_SERIALIZER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define IFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ifs_pkg.sv
// Types and constants shared by the frame serializer modules.
package ifs_pkg;

   localparam int unsigned BYTES_PER_ITEM = 12;
   localparam int unsigned SYNC_BYTES     = 2;
   localparam int unsigned IDX_W          = $clog2(BYTES_PER_ITEM + 1);

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_DATA_IDX = IDX_W'(BYTES_PER_ITEM - 1);
   localparam idx_type CHECKSUM_IDX  = IDX_W'(BYTES_PER_ITEM);
   localparam idx_type FIRST_XOR_IDX = IDX_W'(SYNC_BYTES);

   localparam logic [7:0] SYNC_FIRST   = 8'hA5;
   localparam logic [7:0] SYNC_SECOND  = 8'h5A;
   localparam logic [7:0] OVERFLOW_BIT = 8'h01;

   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // one queued item: preformatted bytes, byte 0 in the low bits
   typedef struct packed {
      logic                          is_header;
      logic                          close;
      logic [BYTES_PER_ITEM*8-1:0]   data;
   } entry_type;

endpackage

FILE: rtl/ifs_fifo.sv
// Small queue of formatted items between the front and back ends.
module ifs_fifo
   import ifs_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/ifs_front.sv
// Front end: accepts words, tracks frame state and formats queue entries.
module ifs_front
   import ifs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [31:0]        req_frame_seq,
   input  logic [7:0]         req_sample_count,
   input  logic               req_overflow_flag,
   input  logic [31:0]        req_drain_time_us,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic               full,
   output logic               push,
   output entry_type          push_entry
);

   logic       frame_open_ff, frame_open_in;
   logic [7:0] samples_left_ff, samples_left_in;
   logic [7:0] left_dec;
   logic [7:0] flag_byte;
   logic       accept;
   logic       is_header;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign is_header = (op_type'(req_op) == OP_HEADER);
   assign left_dec  = samples_left_ff - 8'd1;
   assign flag_byte = req_overflow_flag ? OVERFLOW_BIT : 8'h00;

   always_comb begin
      frame_open_in        = frame_open_ff;
      samples_left_in      = samples_left_ff;
      push                 = 1'b0;
      push_entry.is_header = is_header;
      if (is_header) begin
         push_entry.close = (req_sample_count == 8'd0);
         push_entry.data  = {req_drain_time_us, flag_byte, req_sample_count,
                             req_frame_seq, SYNC_SECOND, SYNC_FIRST};
      end else begin
         push_entry.close = (left_dec == 8'd0);
         push_entry.data  = {req_gyro_z, req_gyro_y, req_gyro_x,
                             req_accel_z, req_accel_y, req_accel_x};
      end
      if (accept) begin
         if (is_header) begin
            push            = 1'b1;
            frame_open_in   = (req_sample_count != 8'd0);
            samples_left_in = req_sample_count;
         end else if (frame_open_ff) begin
            push            = 1'b1;
            frame_open_in   = (left_dec != 8'd0);
            samples_left_in = left_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff   <= 1'b0;
         samples_left_ff <= '0;
      end else begin
         frame_open_ff   <= frame_open_in;
         samples_left_ff <= samples_left_in;
      end
   end

endmodule

FILE: rtl/ifs_back.sv
// Back end: walks the head entry byte by byte, keeps the XOR, drives the output.
module ifs_back
   import ifs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic      rsp_end_of_frame,
   output logic      rsp_last_of_run
);

   idx_type    idx_ff, idx_in;
   logic [7:0] xor_ff, xor_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       eof_ff, eof_in;
   logic       last_ff, last_in;

   logic [7:0] data_bytes [BYTES_PER_ITEM];
   logic [7:0] xor_base;
   logic       load, emit, xor_take, is_checksum;

   always_comb begin
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         data_bytes[i] = head_entry.data[i*8 +: 8];
      end
   end

   assign load        = !rsp_valid_ff || !rsp_stall;
   assign emit        = load && head_valid;
   assign is_checksum = (idx_ff == CHECKSUM_IDX);
   assign xor_base    = (head_entry.is_header && idx_ff == '0) ? 8'h00 : xor_ff;
   assign xor_take    = !is_checksum && !(head_entry.is_header && idx_ff < FIRST_XOR_IDX);
   assign pop         = emit && last_in;

   always_comb begin
      byte_in      = is_checksum ? xor_base : data_bytes[idx_ff];
      eof_in       = is_checksum;
      last_in      = head_entry.close ? is_checksum : (idx_ff == LAST_DATA_IDX);
      idx_in       = idx_ff;
      xor_in       = xor_ff;
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
      if (emit) begin
         idx_in = last_in ? '0 : idx_ff + IDX_W'(1);
         xor_in = xor_take ? (xor_base ^ byte_in) : xor_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         eof_ff  <= eof_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_end_of_frame = eof_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

FILE: rtl/imu_frame_serializer.sv
// Top level of the motion-sensor frame serializer.
// Each header or sample word becomes 12 output bytes, 13 when it closes a frame with the
// XOR checksum byte; bytes leave through a registered output at one per cycle while
// rsp_stall is low, walked out of the queue head byte by byte by the back end.
// A sample word with no open frame is taken but produces nothing. The front
// end accepts words into a queue of QUEUE_DEPTH formatted entries, so input is taken
// while earlier words are still being sent; req_stall rises only when that queue is full.
module imu_frame_serializer
   import ifs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [31:0]        req_frame_seq,
   input  logic [7:0]         req_sample_count,
   input  logic               req_overflow_flag,
   input  logic [31:0]        req_drain_time_us,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_end_of_frame,
   output logic               rsp_last_of_run
);

   logic      push, full, pop, head_valid;
   entry_type push_entry, head_entry;

   ifs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_frame_seq     (req_frame_seq),
      .req_sample_count  (req_sample_count),
      .req_overflow_flag (req_overflow_flag),
      .req_drain_time_us (req_drain_time_us),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_gyro_x        (req_gyro_x),
      .req_gyro_y        (req_gyro_y),
      .req_gyro_z        (req_gyro_z),
      .full              (full),
      .push              (push),
      .push_entry        (push_entry)
   );

   ifs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ifs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

FILE: rtl/ifs_checker.sv
// Port-level assertions for the frame serializer, bound to the top level.
`include "imu_frame_serializer_macros.svh"

module ifs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_out_byte,
   input logic               rsp_end_of_frame,
   input logic               rsp_last_of_run
);

   `IFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_frame) && $stable(rsp_last_of_run), "stalled rsp word changed")
   `IFS_ASSERT_NOW(a_eof_is_last, rsp_valid && rsp_end_of_frame, rsp_last_of_run, "checksum word not last of run")
   `IFS_ASSERT_NEXT(a_run_no_gap, rsp_valid && !rsp_stall && !rsp_last_of_run, rsp_valid, "gap inside a byte run")
   `IFS_ASSERT_NOW(a_idle_after_reset, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind imu_frame_serializer ifs_checker u_ifs_checker (.*);

FILE: verif/imu_frame_serializer_test.sv
// Self-checking testbench for the IMU frame serializer: directed and random frames against a byte predictor.
`timescale 1ns / 100ps

module imu_frame_serializer_test
   import ifs_pkg::*;
();

   localparam int ITEM_TARGET  = 470;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      op_type          op;
      logic [31:0]     seq;
      logic [7:0]      count;
      logic            overflow;
      logic [31:0]     drain;
      logic [5:0][15:0] reading;   // accel x,y,z then gyro x,y,z
   } imu_word_type;

   typedef struct {
      logic [7:0] value;
      logic       eof;
      logic       last;
   } frame_byte_type;

   class frame_scoreboard;
      logic [7:0]     xor_acc;
      logic [7:0]     samples_left;
      bit             in_frame;
      frame_byte_type bytes_due[$];
      int             errors;
      int             headers;
      int             samples;
      int             dropped;
      int             frames_closed;
      int             bytes_checked;

      function new();
         xor_acc = '0;
         samples_left = '0;
         in_frame = 1'b0;
         errors = 0;
         headers = 0;
         samples = 0;
         dropped = 0;
         frames_closed = 0;
         bytes_checked = 0;
      endfunction

      function void push_byte(logic [7:0] value, bit eof, bit in_xor);
         frame_byte_type fb;
         fb.value = value;
         fb.eof = eof;
         fb.last = 1'b0;
         bytes_due.push_back(fb);
         if (in_xor) xor_acc = xor_acc ^ value;
      endfunction

      function void close_frame();
         push_byte(xor_acc, 1'b1, 1'b0);
         in_frame = 1'b0;
         samples_left = '0;
         frames_closed++;
      endfunction

      // predicted bytes for one accepted word; returns how many
      function int note_word(imu_word_type w);
         int n;
         frame_byte_type fb;
         n = bytes_due.size();
         if (w.op == OP_HEADER) begin
            headers++;
            xor_acc = '0;
            push_byte(SYNC_FIRST, 1'b0, 1'b0);
            push_byte(SYNC_SECOND, 1'b0, 1'b0);
            for (int i = 0; i < 4; i++) push_byte(w.seq[8*i +: 8], 1'b0, 1'b1);
            push_byte(w.count, 1'b0, 1'b1);
            push_byte(w.overflow ? OVERFLOW_BIT : 8'h00, 1'b0, 1'b1);
            for (int i = 0; i < 4; i++) push_byte(w.drain[8*i +: 8], 1'b0, 1'b1);
            samples_left = w.count;
            in_frame = 1'b1;
            if (w.count == 8'd0) close_frame();
         end else if (in_frame) begin
            samples++;
            for (int i = 0; i < 6; i++) begin
               push_byte(w.reading[i][7:0], 1'b0, 1'b1);
               push_byte(w.reading[i][15:8], 1'b0, 1'b1);
            end
            samples_left = samples_left - 8'd1;
            if (samples_left == 8'd0) close_frame();
         end else begin
            dropped++;
         end
         n = bytes_due.size() - n;
         if (n > 0) begin
            fb = bytes_due.pop_back();
            fb.last = 1'b1;
            bytes_due.push_back(fb);
         end
         return n;
      endfunction

      function void check_byte(logic [7:0] value, logic eof, logic last);
         frame_byte_type fb;
         if (bytes_due.size() == 0) begin
            $error("unexpected byte %02h (eof %0b, last %0b)", value, eof, last);
            errors++;
            return;
         end
         fb = bytes_due.pop_front();
         bytes_checked++;
         if (value !== fb.value) begin
            $error("out_byte: expected %02h, got %02h", fb.value, value);
            errors++;
         end
         if (eof !== fb.eof) begin
            $error("end_of_frame: expected %0b, got %0b", fb.eof, eof);
            errors++;
         end
         if (last !== fb.last) begin
            $error("last_of_run: expected %0b, got %0b", fb.last, last);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_op;
   logic [31:0]        req_frame_seq;
   logic [7:0]         req_sample_count;
   logic               req_overflow_flag;
   logic [31:0]        req_drain_time_us;
   logic signed [15:0] req_accel_x;
   logic signed [15:0] req_accel_y;
   logic signed [15:0] req_accel_z;
   logic signed [15:0] req_gyro_x;
   logic signed [15:0] req_gyro_y;
   logic signed [15:0] req_gyro_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_out_byte;
   logic               rsp_end_of_frame;
   logic               rsp_last_of_run;

   frame_scoreboard board;
   bit send_steady;
   bit recv_steady;
   bit hold_request;
   int stall_run;
   int holds_done;
   int idle_cycles;

   imu_frame_serializer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_frame_seq     (req_frame_seq),
      .req_sample_count  (req_sample_count),
      .req_overflow_flag (req_overflow_flag),
      .req_drain_time_us (req_drain_time_us),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_gyro_x        (req_gyro_x),
      .req_gyro_y        (req_gyro_y),
      .req_gyro_z        (req_gyro_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_frame  (rsp_end_of_frame),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic imu_word_type make_word(op_type op);
      imu_word_type w;
      w.op = op;
      w.seq = $urandom;
      w.count = 8'($urandom_range(0, 255));
      w.overflow = 1'($urandom_range(0, 1));
      w.drain = $urandom;
      for (int i = 0; i < 6; i++) w.reading[i] = 16'($urandom_range(0, 65535));
      return w;
   endfunction

   function automatic imu_word_type make_header(logic [7:0] count);
      imu_word_type w;
      w = make_word(OP_HEADER);
      w.count = count;
      return w;
   endfunction

   task automatic send_word(imu_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_op <= w.op;
      req_frame_seq <= w.seq;
      req_sample_count <= w.count;
      req_overflow_flag <= w.overflow;
      req_drain_time_us <= w.drain;
      req_accel_x <= w.reading[0];
      req_accel_y <= w.reading[1];
      req_accel_z <= w.reading[2];
      req_gyro_x <= w.reading[3];
      req_gyro_y <= w.reading[4];
      req_gyro_z <= w.reading[5];
      do @(posedge clock); while (req_stall);
      void'(board.note_word(w));
      gap = send_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(logic [7:0] count, int sample_words);
      send_word(make_header(count));
      for (int k = 0; k < sample_words; k++) send_word(make_word(OP_SAMPLE));
   endtask

   // receiver: checks each accepted byte and picks the next stall value
   initial begin
      rsp_stall = 1'b0;
      stall_run = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_byte(rsp_out_byte, rsp_end_of_frame, rsp_last_of_run);
         if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            holds_done++;
            stall_run = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (recv_steady || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_run = pick_gap();
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      imu_word_type w;
      int count;
      int sample_words;
      int frame_idx;

      board = new();
      send_steady = 1'b0;
      recv_steady = 1'b0;
      hold_request = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_HEADER;
      req_frame_seq = '0;
      req_sample_count = '0;
      req_overflow_flag = 1'b0;
      req_drain_time_us = '0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_gyro_x = '0;
      req_gyro_y = '0;
      req_gyro_z = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: stray samples, empty frames, field extremes, abandoned frames
      w = make_word(OP_SAMPLE);
      w.reading = {6{16'h8000}};
      send_word(w);
      w = make_header(8'd0);
      w.seq = '1;
      w.overflow = 1'b1;
      w.drain = '1;
      send_word(w);
      w = make_header(8'd0);
      w.seq = '0;
      w.overflow = 1'b0;
      w.drain = '0;
      send_word(w);
      w = make_word(OP_SAMPLE);
      w.reading = {6{16'h7FFF}};
      send_word(w);
      w = make_header(8'd2);
      w.seq = 32'h1234_5678;
      w.overflow = 1'b0;
      w.drain = 32'h89AB_CDEF;
      send_word(w);
      w = make_word(OP_SAMPLE);
      w.reading = {6{16'h8000}};
      send_word(w);
      w.reading = {6{16'h7FFF}};
      send_word(w);
      w = make_header(8'd3);
      w.overflow = 1'b1;
      send_word(w);
      w = make_word(OP_SAMPLE);
      w.reading = {16'hAAAA, 16'h5555, 16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000};
      send_word(w);
      send_frame(8'd1, 1);
      send_word(make_word(OP_SAMPLE));
      send_frame(8'd255, 2);
      send_frame(8'd1, 1);

      // random frames, mostly well formed
      frame_idx = 0;
      while (board.headers + board.samples < ITEM_TARGET) begin
         send_steady = (frame_idx >= 15 && frame_idx < 20) || frame_idx == 6;
         recv_steady = frame_idx >= 15 && frame_idx < 20;
         if (frame_idx == 6) begin
            hold_request = 1'b1;
            count = 10;
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    count = 0;
               2, 3, 4: count = $urandom_range(7, 30);
               5:       count = $urandom_range(200, 255);
               default: count = $urandom_range(1, 6);
            endcase
         end
         if (count > 40) sample_words = $urandom_range(0, 10);
         else if ($urandom_range(0, 99) < 85) sample_words = count;
         else sample_words = $urandom_range(0, count);
         send_frame(8'(count), sample_words);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_word(make_word(OP_SAMPLE));
         frame_idx++;
      end

      send_steady = 1'b0;
      recv_steady = 1'b1;
      req_valid <= 1'b0;
      while (board.bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d headers and %0d samples in %0d frames, %0d samples ignored.",
               board.headers, board.samples, frame_idx, board.dropped);
      $display("Checked %0d bytes, %0d closed frames, %0d long receiver holds.",
               board.bytes_checked, board.frames_closed, holds_done);
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
